### hdl/bels_pkg.sv
// Shared types and constants for the button event and link supervisor.
package bels_pkg;

	localparam int NUM_LEVELS   = 4;   // button level bits carried per poll
	localparam int IDX_W        = 2;   // scan index width, covers NUM_LEVELS
	localparam int TIME_W       = 32;
	localparam int DUR_W        = 16;
	localparam int ALIVE3_W     = DUR_W + 2;
	localparam int NUM_BUTTONS_DEF = 4;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLASH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALIVE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_HELD = 3'd5;

	localparam logic [DUR_W-1:0]      LOCKOUT_RST = 16'd50;
	localparam logic [DUR_W-1:0]      FLASH_RST   = 16'd100;
	localparam logic [DUR_W-1:0]      BLINK_RST   = 16'd250;
	localparam logic [ALIVE3_W-1:0]   ALIVE3_RST  = 18'd3000;
	localparam logic [NUM_LEVELS-1:0] HELD_RST    = 4'd0;
	localparam logic [TIME_W-1:0]     STAMP_RST   = 32'd1;

	// result codes
	localparam logic [1:0] KIND_BUTTON = 2'd0;
	localparam logic [1:0] KIND_ACK    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ACT_DOWN   = 2'd0;
	localparam logic [1:0] ACT_UP     = 2'd1;
	localparam logic [1:0] ACT_REPEAT = 2'd2;

	localparam logic [1:0] LED_OFF    = 2'd0;
	localparam logic [1:0] LED_DIM    = 2'd1;
	localparam logic [1:0] LED_BRIGHT = 2'd2;

	localparam logic [7:0] REPEAT_INDEX = 8'hFF;

	typedef struct packed {
		logic                  command;
		logic [TIME_W-1:0]     now_ms;
		logic [NUM_LEVELS-1:0] button_levels;
		logic                  packet_valid;
		logic                  packet_is_alive;
	} in_item_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [TIME_W-1:0]     stamp;
		logic [NUM_LEVELS-1:0] held_mask;
		logic [7:0]            button_index;
		logic [1:0]            action;
		logic [1:0]            activity_led;
		logic                  error_led;
		logic                  link_lost;
		logic                  last;
	} out_item_t;

	// work classes handed from front to back
	typedef enum logic [1:0] {
		OP_POLL,
		OP_ALIVE,
		OP_PACKET,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [TIME_W-1:0]     now_ms;
		logic [NUM_LEVELS-1:0] levels;
	} work_t;

	typedef struct packed {
		logic [DUR_W-1:0]    lockout;
		logic [DUR_W-1:0]    flash;
		logic [DUR_W-1:0]    blink;
		logic [ALIVE3_W-1:0] alive3;
		logic                init_fault;
	} cfg_t;

endpackage

### hdl/bels_front.sv
// Front end: accepts input items, classifies them and queues work for the back end.
module bels_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bels_pkg::in_item_t in_data,
	output logic              work_valid,
	input  logic              work_pop,
	output bels_pkg::work_t   work
);

	localparam int DEPTH = 2;

	bels_pkg::work_t mem_q [DEPTH];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      count_q;
	bels_pkg::work_t cls;
	logic            push, pop;

	always_comb begin
		cls.now_ms = in_data.now_ms;
		cls.levels = in_data.button_levels;
		priority if (!in_data.command)
			cls.op = bels_pkg::OP_POLL;
		else if (in_data.packet_valid && in_data.packet_is_alive)
			cls.op = bels_pkg::OP_ALIVE;
		else if (in_data.packet_valid)
			cls.op = bels_pkg::OP_PACKET;
		else
			cls.op = bels_pkg::OP_NOP;
	end

	assign in_stall   = (count_q == 2'(DEPTH));
	assign work_valid = (count_q != 2'd0);
	assign work       = mem_q[rd_ptr_q];
	assign push       = in_valid && !in_stall;
	assign pop        = work_pop && work_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### hdl/bels_back.sv
// Back end: sequencer that scans buttons, runs the LED and link timers and emits results.
module bels_back #(
	parameter int NUM_BUTTONS = bels_pkg::NUM_BUTTONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bels_pkg::cfg_t                    cfg,
	input  logic                              held_load,
	input  logic [bels_pkg::NUM_LEVELS-1:0]   held_value,
	input  logic                              work_valid,
	output logic                              work_pop,
	input  bels_pkg::work_t                   work,
	output logic                              out_valid,
	input  logic                              out_stall,
	output bels_pkg::out_item_t               out_data
);

	localparam int SCAN_N = (NUM_BUTTONS < bels_pkg::NUM_LEVELS) ?
		NUM_BUTTONS : bels_pkg::NUM_LEVELS;
	localparam logic [bels_pkg::IDX_W-1:0] SCAN_LAST = bels_pkg::IDX_W'(SCAN_N - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ACT,
		S_ERR,
		S_ACK,
		S_PKT,
		S_STATUS
	} state_t;

	state_t                            state_q;
	bels_pkg::work_t                   cur_q;
	logic [bels_pkg::NUM_LEVELS-1:0]   held_q;
	logic [bels_pkg::TIME_W-1:0]       last_event_q, activity_q, blink_q, stamp_q;
	logic                              lost_q, error_q, scan_en_q, alive_hit_q;
	logic [1:0]                        level_q;
	logic [bels_pkg::IDX_W-1:0]        idx_q;
	logic                              out_valid_q;
	bels_pkg::out_item_t               out_q;

	logic                              slot_free, emit, blocked;
	bels_pkg::out_item_t               res;
	logic [bels_pkg::NUM_LEVELS-1:0]   bit_sel;
	logic                              was, high, change;
	logic [bels_pkg::TIME_W-1:0]       lock_diff, act_diff, blink_diff;

	assign slot_free = !out_valid_q || !out_stall;
	assign bit_sel   = bels_pkg::NUM_LEVELS'(1) << idx_q;
	assign was       = |(held_q & bit_sel);
	assign high      = |(cur_q.levels & bit_sel);
	assign change    = scan_en_q && (was != high);
	assign lock_diff  = work.now_ms - last_event_q;
	assign act_diff   = cur_q.now_ms - activity_q;
	assign blink_diff = cur_q.now_ms - blink_q;
	assign work_pop   = (state_q == S_IDLE) && work_valid;

	always_comb begin
		emit = 1'b0;
		res  = '0;
		unique case (state_q)
			S_SCAN: begin
				if (change) begin
					emit               = 1'b1;
					res.kind           = bels_pkg::KIND_BUTTON;
					res.stamp          = stamp_q;
					res.held_mask      = held_q ^ bit_sel;
					res.button_index   = 8'(idx_q);
					res.action         = high ? bels_pkg::ACT_DOWN : bels_pkg::ACT_UP;
				end
			end
			S_ACK: begin
				emit     = 1'b1;
				res.kind = bels_pkg::KIND_ACK;
			end
			S_PKT: begin
				if (lost_q) begin
					emit             = 1'b1;
					res.kind         = bels_pkg::KIND_BUTTON;
					res.stamp        = stamp_q;
					res.held_mask    = held_q;
					res.button_index = bels_pkg::REPEAT_INDEX;
					res.action       = bels_pkg::ACT_REPEAT;
				end
			end
			S_STATUS: begin
				emit             = 1'b1;
				res.kind         = bels_pkg::KIND_STATUS;
				res.stamp        = stamp_q;
				res.held_mask    = held_q;
				res.activity_led = level_q;
				res.error_led    = error_q;
				res.link_lost    = lost_q;
				res.last         = 1'b1;
			end
			default: ;
		endcase
	end

	assign blocked = emit && !slot_free;

	always_ff @(posedge clk) begin
		if (work_pop)
			cur_q <= work;
		if (emit && slot_free)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			held_q       <= bels_pkg::HELD_RST;
			last_event_q <= '0;
			activity_q   <= '0;
			blink_q      <= '0;
			stamp_q      <= bels_pkg::STAMP_RST;
			lost_q       <= 1'b0;
			error_q      <= 1'b0;
			level_q      <= bels_pkg::LED_OFF;
			scan_en_q    <= 1'b0;
			alive_hit_q  <= 1'b0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit && slot_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (held_load)
				held_q <= held_value;

			if (!blocked) begin
				unique case (state_q)
					S_IDLE: begin
						if (work_valid) begin
							scan_en_q <= lock_diff >= {16'd0, cfg.lockout};
							idx_q     <= '0;
							unique case (work.op)
								bels_pkg::OP_POLL:   state_q <= S_SCAN;
								bels_pkg::OP_ALIVE:  state_q <= S_ACK;
								bels_pkg::OP_PACKET: state_q <= S_PKT;
								bels_pkg::OP_NOP:    state_q <= S_STATUS;
								default:             state_q <= S_STATUS;
							endcase
						end
					end
					S_SCAN: begin
						if (change) begin
							held_q       <= held_q ^ bit_sel;
							stamp_q      <= stamp_q + 32'd1;
							last_event_q <= cur_q.now_ms;
							if (high) begin
								activity_q <= cur_q.now_ms;
								level_q    <= bels_pkg::LED_OFF;
							end
						end
						if (idx_q == SCAN_LAST)
							state_q <= S_ACT;
						else
							idx_q <= idx_q + bels_pkg::IDX_W'(1);
					end
					S_ACT: begin
						if (act_diff >= {16'd0, cfg.flash})
							level_q <= bels_pkg::LED_DIM;
						alive_hit_q <= act_diff >= {14'd0, cfg.alive3};
						state_q     <= S_ERR;
					end
					S_ERR: begin
						if (lost_q) begin
							if (blink_diff >= {16'd0, cfg.blink}) begin
								blink_q <= cur_q.now_ms;
								error_q <= ~error_q;
							end
						end else begin
							error_q <= cfg.init_fault;
							if (alive_hit_q)
								lost_q <= 1'b1;
						end
						state_q <= S_STATUS;
					end
					S_ACK: state_q <= S_PKT;
					S_PKT: begin
						activity_q <= cur_q.now_ms;
						level_q    <= bels_pkg::LED_BRIGHT;
						lost_q     <= 1'b0;
						state_q    <= S_STATUS;
					end
					S_STATUS: state_q <= S_IDLE;
					default:  state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hdl/button_event_link_supervisor.sv
// Top level: configuration registers, front end queue and back end sequencer.
// Every input item ends with a status item as its last result.
// A poll steps the back-end sequencer through a scan of min(NUM_BUTTONS, 4) buttons,
// then ACT, ERR and STATUS, a packet through ACK (alive), PKT (valid) and STATUS; a stalled result holds it.
// The front end queues two items, so input transfers continue while the back end works, until the queue is full.
// Reset (arst_n low, asynchronous) restores register defaults, empties the queue and
// output register, clears held buttons and timers and sets the event stamp to 1.
module button_event_link_supervisor #(
	parameter int NUM_BUTTONS = bels_pkg::NUM_BUTTONS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  bels_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output bels_pkg::out_item_t                 out_data,
	input  logic                                wr_en,
	input  logic [bels_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [bels_pkg::DUR_W-1:0]          wr_data
);

	bels_pkg::cfg_t  cfg_q;
	logic            held_load;
	logic            work_valid, work_pop;
	bels_pkg::work_t work;

	assign held_load = wr_en && (wr_index == bels_pkg::REG_INIT_HELD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout    <= bels_pkg::LOCKOUT_RST;
			cfg_q.flash      <= bels_pkg::FLASH_RST;
			cfg_q.blink      <= bels_pkg::BLINK_RST;
			cfg_q.alive3     <= bels_pkg::ALIVE3_RST;
			cfg_q.init_fault <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				bels_pkg::REG_LOCKOUT: cfg_q.lockout <= wr_data;
				bels_pkg::REG_FLASH:   cfg_q.flash   <= wr_data;
				bels_pkg::REG_BLINK:   cfg_q.blink   <= wr_data;
				// keep three alive periods ready for the link-loss compare
				bels_pkg::REG_ALIVE:
					cfg_q.alive3 <= {2'b00, wr_data} + {1'b0, wr_data, 1'b0};
				bels_pkg::REG_FAULT:   cfg_q.init_fault <= wr_data[0];
				default: ;
			endcase
		end
	end

	bels_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.work_valid (work_valid),
		.work_pop   (work_pop),
		.work       (work)
	);

	bels_back #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.held_load  (held_load),
		.held_value (wr_data[bels_pkg::NUM_LEVELS-1:0]),
		.work_valid (work_valid),
		.work_pop   (work_pop),
		.work       (work),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

`ifndef ASSERT_OFF
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == (out_data.kind == bels_pkg::KIND_STATUS)))
		else $error("last flag does not match status kind");

	a_repeat_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.action == bels_pkg::ACT_REPEAT) |->
		(out_data.kind == bels_pkg::KIND_BUTTON &&
		 out_data.button_index == bels_pkg::REPEAT_INDEX))
		else $error("malformed repeat packet");

	a_ack_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == bels_pkg::KIND_ACK) |->
		(out_data.stamp == '0 && out_data.held_mask == '0 && !out_data.last))
		else $error("acknowledge carries payload");
`endif

endmodule

### verif/bels_scoreboard_pkg.sv
// Scoreboard for the button event and link supervisor: predicts results and checks them in order.
package bels_scoreboard_pkg;

	localparam logic CMD_POLL   = 1'b0;
	localparam logic CMD_PACKET = 1'b1;

	class supervisor_scoreboard;
		// register copies
		logic [bels_pkg::DUR_W-1:0]      lockout, flash, blink, alive;
		logic                            fault;
		// supervisor state
		logic [bels_pkg::NUM_LEVELS-1:0] held;
		logic [bels_pkg::TIME_W-1:0]     last_event_time, activity_time, blink_time, stamp;
		logic                            lost;
		logic [1:0]                      act_level;
		logic                            error_on;

		bels_pkg::out_item_t             expected_results[$];
		int                              mismatches;

		function new();
			lockout = bels_pkg::LOCKOUT_RST;
			flash = bels_pkg::FLASH_RST;
			blink = bels_pkg::BLINK_RST;
			alive = 16'd1000;
			fault = 1'b0;
			held = bels_pkg::HELD_RST;
			last_event_time = '0;
			activity_time = '0;
			blink_time = '0;
			stamp = bels_pkg::STAMP_RST;
			lost = 1'b0;
			act_level = bels_pkg::LED_OFF;
			error_on = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [bels_pkg::CFG_IDX_W-1:0] idx,
				logic [bels_pkg::DUR_W-1:0] value);
			case (idx)
				bels_pkg::REG_LOCKOUT: lockout = value;
				bels_pkg::REG_FLASH: flash = value;
				bels_pkg::REG_BLINK: blink = value;
				bels_pkg::REG_ALIVE: alive = value;
				bels_pkg::REG_FAULT: fault = value[0];
				// takes effect at once
				bels_pkg::REG_INIT_HELD: held = value[bels_pkg::NUM_LEVELS-1:0];
				default: ;
			endcase
		endfunction

		function void expect_result(logic [1:0] kind, logic [bels_pkg::TIME_W-1:0] st,
				logic [bels_pkg::NUM_LEVELS-1:0] mask, logic [7:0] idx, logic [1:0] act,
				logic [1:0] aled, logic eled, logic lnk, logic fin);
			bels_pkg::out_item_t r;
			r.kind = kind;
			r.stamp = st;
			r.held_mask = mask;
			r.button_index = idx;
			r.action = act;
			r.activity_led = aled;
			r.error_led = eled;
			r.link_lost = lnk;
			r.last = fin;
			expected_results.push_back(r);
		endfunction

		function void note_input(bels_pkg::in_item_t it);
			logic [bels_pkg::TIME_W-1:0] now;
			logic [bels_pkg::TIME_W-1:0] alive3;
			now = it.now_ms;
			alive3 = 32'(alive) * 32'd3;
			if (it.command == CMD_POLL) begin
				if (32'(now - last_event_time) >= 32'(lockout)) begin
					for (int b = 0; b < bels_pkg::NUM_LEVELS; b++) begin
						if (!held[b] && it.button_levels[b]) begin
							held[b] = 1'b1;
							activity_time = now;
							act_level = bels_pkg::LED_OFF;
							expect_result(bels_pkg::KIND_BUTTON, stamp, held, 8'(b),
								bels_pkg::ACT_DOWN, bels_pkg::LED_OFF, 1'b0, 1'b0, 1'b0);
							stamp = stamp + 32'd1;
							last_event_time = now;
						end else if (held[b] && !it.button_levels[b]) begin
							held[b] = 1'b0;
							expect_result(bels_pkg::KIND_BUTTON, stamp, held, 8'(b),
								bels_pkg::ACT_UP, bels_pkg::LED_OFF, 1'b0, 1'b0, 1'b0);
							stamp = stamp + 32'd1;
							last_event_time = now;
						end
					end
				end
				if (32'(now - activity_time) >= 32'(flash))
					act_level = bels_pkg::LED_DIM;
				if (lost) begin
					if (32'(now - blink_time) >= 32'(blink)) begin
						blink_time = now;
						error_on = !error_on;
					end
				end else begin
					error_on = fault;
				end
				if (!lost && 32'(now - activity_time) >= alive3)
					lost = 1'b1;
			end else if (it.packet_valid) begin
				if (it.packet_is_alive)
					expect_result(bels_pkg::KIND_ACK, '0, '0, 8'd0, bels_pkg::ACT_DOWN,
						bels_pkg::LED_OFF, 1'b0, 1'b0, 1'b0);
				activity_time = now;
				act_level = bels_pkg::LED_BRIGHT;
				// link was down: resend the held mask
				if (lost)
					expect_result(bels_pkg::KIND_BUTTON, stamp, held, bels_pkg::REPEAT_INDEX,
						bels_pkg::ACT_REPEAT, bels_pkg::LED_OFF, 1'b0, 1'b0, 1'b0);
				lost = 1'b0;
			end
			expect_result(bels_pkg::KIND_STATUS, stamp, held, 8'd0, bels_pkg::ACT_DOWN,
				act_level, error_on, lost, 1'b1);
		endfunction

		function string show(bels_pkg::out_item_t r);
			return $sformatf({"kind=%0d stamp=%h held=%h idx=%0d act=%0d",
				" aled=%0d eled=%0d lost=%0d last=%0d"},
				r.kind, r.stamp, r.held_mask, r.button_index, r.action, r.activity_led,
				r.error_led, r.link_lost, r.last);
		endfunction

		function void note_failure(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_result(bels_pkg::out_item_t got);
			bels_pkg::out_item_t exp_r;
			string diffs;
			if (expected_results.size() == 0) begin
				note_failure({"result with nothing outstanding: ", show(got)});
				return;
			end
			exp_r = expected_results.pop_front();
			diffs = "";
			if (got.kind !== exp_r.kind) diffs = {diffs, " kind"};
			if (got.stamp !== exp_r.stamp) diffs = {diffs, " stamp"};
			if (got.held_mask !== exp_r.held_mask) diffs = {diffs, " held_mask"};
			if (got.button_index !== exp_r.button_index) diffs = {diffs, " button_index"};
			if (got.action !== exp_r.action) diffs = {diffs, " action"};
			if (got.activity_led !== exp_r.activity_led) diffs = {diffs, " activity_led"};
			if (got.error_led !== exp_r.error_led) diffs = {diffs, " error_led"};
			if (got.link_lost !== exp_r.link_lost) diffs = {diffs, " link_lost"};
			if (got.last !== exp_r.last) diffs = {diffs, " last"};
			if (diffs != "")
				note_failure({"mismatch on", diffs, ": expected ", show(exp_r),
					" got ", show(got)});
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

endpackage

### verif/button_event_link_supervisor_test.sv
// Testbench top for the button event and link supervisor: directed and random traffic.
module button_event_link_supervisor_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int NUM_PHASES  = 7;
	localparam int PHASE_ITEMS = 55;
	localparam logic CMD_POLL   = bels_scoreboard_pkg::CMD_POLL;
	localparam logic CMD_PACKET = bels_scoreboard_pkg::CMD_PACKET;
	localparam int TIME_W     = bels_pkg::TIME_W;
	localparam int DUR_W      = bels_pkg::DUR_W;
	localparam int NUM_LEVELS = bels_pkg::NUM_LEVELS;
	localparam int CFG_IDX_W  = bels_pkg::CFG_IDX_W;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	bels_pkg::in_item_t   in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	bels_pkg::out_item_t  out_data;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = bels_pkg::REG_LOCKOUT;
	logic [DUR_W-1:0]     wr_data = '0;

	bels_scoreboard_pkg::supervisor_scoreboard sb;
	int                   cycles = 0;
	logic                 calm = 1'b0;     // no gaps and no stalls while set
	logic [TIME_W-1:0]    cur_ms = '0;
	logic [DUR_W-1:0]     cfg_lockout = bels_pkg::LOCKOUT_RST;
	logic [DUR_W-1:0]     cfg_blink = bels_pkg::BLINK_RST;
	logic [DUR_W-1:0]     cfg_alive = 16'd1000;

	button_event_link_supervisor uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic bels_pkg::in_item_t mk(logic cmd, logic [TIME_W-1:0] now,
			logic [NUM_LEVELS-1:0] levels, logic pvalid, logic palive);
		bels_pkg::in_item_t it;
		it.command = cmd;
		it.now_ms = now;
		it.button_levels = levels;
		it.packet_valid = pvalid;
		it.packet_is_alive = palive;
		return it;
	endfunction

	task automatic send_item(input bels_pkg::in_item_t it);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		cur_ms = it.now_ms;
	endtask

	// hold off the sender until every result is back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] value);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = value;
		@(posedge clk);
		sb.write_reg(idx, value);
		case (idx)
			bels_pkg::REG_LOCKOUT: cfg_lockout = value;
			bels_pkg::REG_BLINK: cfg_blink = value;
			bels_pkg::REG_ALIVE: cfg_alive = value;
			default: ;
		endcase
	endtask

	task automatic configure(input int phase);
		logic [DUR_W-1:0] lk, fl, bl, al;
		logic             flt;
		logic [3:0]       ih;
		if (phase == 0) begin
			lk = '0; fl = '0; bl = '0; al = '0; flt = 1'b1; ih = 4'hF;
		end else if (phase == 1) begin
			lk = '1; fl = '1; bl = '1; al = '1; flt = 1'b0; ih = 4'h0;
		end else begin
			lk = 16'($urandom_range(0, 200));
			fl = 16'($urandom_range(0, 400));
			bl = 16'($urandom_range(0, 300));
			al = 16'($urandom_range(0, 200));
			flt = 1'($urandom_range(0, 1));
			ih = 4'($urandom_range(0, 15));
		end
		write_reg(bels_pkg::REG_LOCKOUT, lk);
		write_reg(bels_pkg::REG_FLASH, fl);
		write_reg(bels_pkg::REG_BLINK, bl);
		write_reg(bels_pkg::REG_ALIVE, al);
		write_reg(bels_pkg::REG_FAULT, 16'(flt));
		write_reg(bels_pkg::REG_INIT_HELD, 16'(ih));
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic run_random(input int count);
		logic [NUM_LEVELS-1:0] levels;
		logic [TIME_W-1:0]     now;
		int                    r;
		levels = 4'($urandom_range(0, 15));
		for (int i = 0; i < count; i++) begin
			calm = (i % 40) < 8;
			r = $urandom_range(0, 99);
			if (r < 60)
				now = cur_ms + $urandom_range(0, 32'(cfg_lockout) * 2 + 5);
			else if (r < 85)
				now = cur_ms + $urandom_range(0, 32'(cfg_blink) * 2 + 5);
			else if (r < 95)
				now = cur_ms + $urandom_range(0, 32'(cfg_alive) * 4 + 5);
			else
				now = $urandom();
			if ($urandom_range(0, 9) < 3)
				levels = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 99) < 15)
				send_item(mk(CMD_PACKET, now, 4'($urandom_range(0, 15)),
					$urandom_range(0, 99) < 85, 1'($urandom_range(0, 1))));
			else
				send_item(mk(CMD_POLL, now, levels, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1))));
		end
		calm = 1'b0;
	endtask

	// result side: check every transfer, stall at random
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			@(negedge clk);
			if (calm) begin
				stall_left = 0;
				out_stall = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					stall_left = 0;
				else if (r < 95)
					stall_left = $urandom_range(1, 3);
				else
					stall_left = $urandom_range(10, 30);
				out_stall = stall_left > 0;
			end
		end
	end

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: lockout 50, flash 100, blink 250, alive 1000
		send_item(mk(CMD_POLL, 32'd0, 4'h0, 1'b1, 1'b1));   // inside lockout
		send_item(mk(CMD_POLL, 32'd60, 4'hF, 1'b0, 1'b0));  // four presses
		send_item(mk(CMD_POLL, 32'd70, 4'h0, 1'b1, 1'b0));  // still locked out
		send_item(mk(CMD_POLL, 32'd110, 4'h0, 1'b0, 1'b1)); // four releases
		send_item(mk(CMD_PACKET, 32'd120, 4'hF, 1'b1, 1'b1));
		send_item(mk(CMD_PACKET, 32'd130, 4'h0, 1'b0, 1'b1)); // bad packet
		send_item(mk(CMD_POLL, 32'd3200, 4'h0, 1'b0, 1'b0));  // link drops
		send_item(mk(CMD_POLL, 32'd3300, 4'h0, 1'b0, 1'b0));  // blink on
		send_item(mk(CMD_POLL, 32'd3400, 4'h0, 1'b0, 1'b0));
		send_item(mk(CMD_POLL, 32'd3600, 4'h0, 1'b0, 1'b0));  // blink off
		send_item(mk(CMD_POLL, 32'd3700, 4'h5, 1'b1, 1'b1));
		send_item(mk(CMD_PACKET, 32'd3710, 4'hA, 1'b1, 1'b0)); // repeat only
		send_item(mk(CMD_POLL, 32'd6800, 4'h5, 1'b0, 1'b0));
		send_item(mk(CMD_PACKET, 32'd6810, 4'hF, 1'b1, 1'b1)); // ack and repeat
		send_item(mk(CMD_POLL, 32'hFFFF_FFF0, 4'hA, 1'b0, 1'b0));
		send_item(mk(CMD_POLL, 32'h0000_0010, 4'h0, 1'b0, 1'b0)); // wrapped, locked out
		send_item(mk(CMD_POLL, 32'h0000_0030, 4'h0, 1'b0, 1'b0));
		send_item(mk(CMD_POLL, 32'h8000_0000, 4'hF, 1'b0, 1'b0));
		send_item(mk(CMD_POLL, 32'h7FFF_FFFF, 4'h0, 1'b0, 1'b0));
		send_item(mk(CMD_PACKET, 32'h5555_5555, 4'h0, 1'b1, 1'b0));
		send_item(mk(CMD_POLL, 32'hAAAA_AAAA, 4'h3, 1'b1, 1'b1));

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			configure(p);
			run_random(PHASE_ITEMS);
		end
		drain();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
